/* sv/bta_pkg.sv */
`timescale 1ns / 1ps

package bta_pkg;

  // table geometry
  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 4096;

  localparam int BLK_W   = $clog2(NUM_BLOCKS);       // block index
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);   // block count incl. NUM_BLOCKS
  localparam int BYTE_SH = $clog2(BLOCK_BYTES);      // byte to block shift
  localparam int NEED_W  = 33 - BYTE_SH;             // rounded-up block count of a size

  localparam int ENTRY_W = 3;
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 32;
  localparam int STAT_W  = 2;
  localparam int BCNT_W  = 11;
  localparam int CIDX_W  = 2;

  // entry flags
  localparam logic [ENTRY_W-1:0] FLAG_TAKEN = 3'h1;
  localparam logic [ENTRY_W-1:0] FLAG_FIRST = 3'h2;
  localparam logic [ENTRY_W-1:0] FLAG_NEXT  = 3'h4;
  localparam logic [7:0]         TYPE_MASK  = 8'h0f;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [STAT_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [BLK_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [BLK_W-1:0]   raddr;
  } ram_req_t;

endpackage

/* sv/block_table_heap_allocator.sv */
`timescale 1ns / 1ps
// flow: alloc scans table entries for a free run, then marks its blocks, before the result
//   beat; free clears the entries along the chain, and a rejected request goes straight to
//   the result; the single table ram port pair is walked one entry a cycle
// throughput: one request at a time; a finished result waits in the output register
// reset: synchronous active-low; a clearing pass then writes NUM_BLOCKS (1024) entries,
//   one a cycle, with in_tready low; config writes are taken throughout

module block_table_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // request_size [31:0], free_address [63:32]
  input  logic        in_tuser,   // command (0 alloc, 1 free)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_address [31:0], status [33:32], zero pad
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bta_pkg::CIDX_W-1:0] cfg_addr,
  input  logic [31:0] cfg_data
);
  import bta_pkg::*;

  // config registers
  logic [ADDR_W-1:0] heap_base_r;
  logic [BCNT_W-1:0] block_count_r;
  logic [CNT_W-1:0]  lim;

  // engine hookup
  item_t              item;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  // output register
  logic        out_valid_r;
  res_t        out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      block_count_r <= BCNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_addr == REG_HEAP_BASE) heap_base_r <= cfg_data;
      if (cfg_addr == REG_BLOCK_COUNT) block_count_r <= cfg_data[BCNT_W-1:0];
    end
  end

  // block count clamped to the table depth
  assign lim = (32'(block_count_r) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(block_count_r);

  assign item.command      = in_tuser;
  assign item.request_size = in_tdata[31:0];
  assign item.free_address = in_tdata[63:32];

  bta_table_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  bta_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item        (item),
    .heap_base   (heap_base_r),
    .lim         (lim),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // result slot takes a new beat when empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.status, out_res_r.result_address};

  // the engine works one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while engine busy");

  // the chain walk never reads the entry it is writing in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("table read and write hit the same entry");

  // only a good allocation carries an address
  a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_res_r.status != ST_OK)) |-> (out_res_r.result_address == '0))
    else $error("error result with nonzero address");

endmodule

/* sv/bta_table_ram.sv */
`timescale 1ns / 1ps

module bta_table_ram (
  input  logic                      clk,
  input  bta_pkg::ram_req_t         req,
  output logic [bta_pkg::ENTRY_W-1:0] rd_data
);
  import bta_pkg::*;

  logic [ENTRY_W-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

/* sv/bta_engine.sv */
`timescale 1ns / 1ps

module bta_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bta_pkg::item_t                item,
  input  logic [bta_pkg::ADDR_W-1:0]    heap_base,
  input  logic [bta_pkg::CNT_W-1:0]     lim,
  output bta_pkg::ram_req_t             ram_req,
  input  logic [bta_pkg::ENTRY_W-1:0]   ram_rd_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bta_pkg::res_t                 res
);
  import bta_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [BLK_W-1:0] chk_r, chk_nxt;
  logic [BLK_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  res_t             res_r, res_nxt;

  logic [NEED_W-1:0] need_w;
  logic              need_big;
  logic [ADDR_W-1:0] off_w;
  logic [ADDR_W-1:0] blk_w;
  logic              out_of_range;
  logic [CNT_W-1:0]  run_inc;
  logic [CNT_W-1:0]  chk_inc;
  logic              at_end;
  logic [BLK_W-1:0]  start_sel;
  logic [ENTRY_W-1:0] mark_entry;

  // request decode at the accept beat
  assign need_w   = NEED_W'(item.request_size >> BYTE_SH)
                  + NEED_W'(|item.request_size[BYTE_SH-1:0]);
  assign need_big = 33'(need_w) > 33'(lim);
  assign off_w    = item.free_address - heap_base;
  assign blk_w    = off_w >> BYTE_SH;
  assign out_of_range = (item.free_address < heap_base) || (blk_w >= ADDR_W'(lim));

  assign run_inc   = run_r + CNT_W'(1);
  assign chk_inc   = CNT_W'(chk_r) + CNT_W'(1);
  assign at_end    = chk_inc >= lim;
  assign start_sel = (run_r == '0) ? chk_r : start_r;

  always_comb begin
    mark_entry = FLAG_TAKEN;
    if (run_r == '0) mark_entry = mark_entry | FLAG_FIRST;
    if (run_inc < need_r) mark_entry = mark_entry | FLAG_NEXT;
  end

  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_RESP);
  assign res        = res_r;

  always_comb begin
    state_nxt = state_r;
    chk_nxt   = chk_r;
    start_nxt = start_r;
    run_nxt   = run_r;
    need_nxt  = need_r;
    res_nxt   = res_r;
    ram_req   = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = chk_r;
        ram_req.wdata = '0;
        if (chk_r == LAST_BLK) begin
          state_nxt = S_IDLE;
          chk_nxt   = '0;
        end else begin
          chk_nxt = chk_r + BLK_W'(1);
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          res_nxt.result_address = '0;
          res_nxt.status         = ST_OK;
          if (item.command == CMD_ALLOC) begin
            if (item.request_size == '0) begin
              res_nxt.status = ST_ZERO;
              state_nxt      = S_RESP;
            end else if (need_big) begin
              res_nxt.status = ST_NOSPACE;
              state_nxt      = S_RESP;
            end else begin
              need_nxt      = CNT_W'(need_w);
              run_nxt       = '0;
              chk_nxt       = '0;
              ram_req.re    = 1'b1;
              ram_req.raddr = '0;
              state_nxt     = S_SCAN;
            end
          end else begin
            if (out_of_range) begin
              res_nxt.status = ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              chk_nxt       = BLK_W'(blk_w);
              ram_req.re    = 1'b1;
              ram_req.raddr = BLK_W'(blk_w);
              state_nxt     = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        // ram_rd_data holds the entry of block chk_r
        if ((8'(ram_rd_data) & TYPE_MASK & 8'(FLAG_TAKEN)) == 8'h00) begin
          start_nxt = start_sel;
          run_nxt   = run_inc;
          if (run_inc == need_r) begin
            run_nxt   = '0;
            state_nxt = S_MARK;
          end
        end else begin
          run_nxt = '0;
        end
        if (state_nxt == S_SCAN) begin
          if (at_end) begin
            res_nxt.status = ST_NOSPACE;
            state_nxt      = S_RESP;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = BLK_W'(chk_inc);
            chk_nxt       = BLK_W'(chk_inc);
          end
        end
      end
      S_MARK: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = start_r + BLK_W'(run_r);
        ram_req.wdata = mark_entry;
        run_nxt       = run_inc;
        if (run_inc == need_r) begin
          res_nxt.result_address = heap_base + (ADDR_W'(start_r) << BYTE_SH);
          res_nxt.status         = ST_OK;
          state_nxt              = S_RESP;
        end
      end
      S_FREE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = chk_r;
        ram_req.wdata = '0;
        if (((ram_rd_data & FLAG_NEXT) != '0) && !at_end) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = BLK_W'(chk_inc);
          chk_nxt       = BLK_W'(chk_inc);
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      chk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    run_r   <= run_nxt;
    need_r  <= need_nxt;
    res_r   <= res_nxt;
  end

endmodule

/* dv/block_table_heap_allocator_test.sv */
`timescale 1ns / 1ps

module block_table_heap_allocator_test;
  import bta_pkg::*;

  // an index that decodes to no register, the write must be dropped
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;
  // longest single request: full scan plus full mark, with some margin
  localparam int DRAIN_CYCLES = 2 * NUM_BLOCKS + 16;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;    // request_size [31:0], free_address [63:32]
  logic        in_tuser   = 1'b0;  // command (0 alloc, 1 free)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // result_address [31:0], status [33:32], zero pad
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [CIDX_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_data   = '0;

  // both sides run without idle cycles while this is set
  bit steady_flow = 1'b0;
  int mismatches  = 0;

  // shadow copy of the block table and of the two registers
  logic [ENTRY_W-1:0] shadow_table [NUM_BLOCKS];
  logic [ADDR_W-1:0]  shadow_base;
  logic [BCNT_W-1:0]  shadow_count;

  // answers still owed by the allocator, oldest first
  res_t owed_answers[$];

  always #1 clk = ~clk;

  block_table_heap_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // counts above the table size are clamped to the table size
  function automatic int usable_blocks();
    return (shadow_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(shadow_count);
  endfunction

  // first-fit allocate or chain release on the shadow table, returns the answer
  function automatic res_t allocator_answer(logic cmd, logic [SIZE_W-1:0] size,
                                            logic [ADDR_W-1:0] addr);
    res_t               ans;
    int                 lim;
    int                 run;
    int                 start;
    int                 i;
    longint             need;
    longint             blk;
    bit                 found;
    bit                 chained;
    logic [ENTRY_W-1:0] entry;
    ans = '0;
    ans.status = ST_OK;
    lim = usable_blocks();
    if (cmd == CMD_ALLOC) begin
      if (size == '0) begin
        ans.status = ST_ZERO;
      end else begin
        // round the byte count up to whole blocks without 32-bit overflow
        need  = ({32'b0, size} + BLOCK_BYTES - 1) / BLOCK_BYTES;
        found = 1'b0;
        run   = 0;
        start = 0;
        if (need <= lim) begin
          for (i = 0; i < lim && !found; i++) begin
            if ((shadow_table[i] & FLAG_TAKEN) != '0) begin
              run = 0;
            end else begin
              if (run == 0) start = i;
              run++;
              if (run == need) found = 1'b1;
            end
          end
        end
        if (!found) begin
          ans.status = ST_NOSPACE;
        end else begin
          for (i = 0; i < need; i++) begin
            entry = FLAG_TAKEN;
            if (i == 0) entry |= FLAG_FIRST;
            if (i + 1 < need) entry |= FLAG_NEXT;
            shadow_table[start + i] = entry;
          end
          // wraps modulo 2^32
          ans.result_address = shadow_base + 32'(start * BLOCK_BYTES);
        end
      end
    end else begin
      if (addr < shadow_base) begin
        ans.status = ST_RANGE;
      end else begin
        blk = (addr - shadow_base) / BLOCK_BYTES;
        if (blk >= lim) begin
          ans.status = ST_RANGE;
        end else begin
          // clear along the has-next chain, never past the usable count
          chained = 1'b1;
          for (i = int'(blk); i < lim && chained; i++) begin
            entry           = shadow_table[i];
            shadow_table[i] = '0;
            chained         = (entry & FLAG_NEXT) != '0;
          end
        end
      end
    end
    return ans;
  endfunction

  // one request beat; valid stays high afterwards so back-to-back beats never
  // lower and raise it in the same step
  task automatic send_request(logic cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    while (!steady_flow && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {addr, size};
    do @(posedge clk); while (!in_tready);
    owed_answers.push_back(allocator_answer(cmd, size, addr));
  endtask

  // drop valid and wait until every owed answer has come back
  task automatic settle_requests();
    in_tvalid <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk);
  endtask

  // cfg valid is left high so consecutive writes need no idle cycle
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEAP_BASE:   shadow_base  = value;
      REG_BLOCK_COUNT: shadow_count = value[BCNT_W-1:0];
      default: ;
    endcase
  endtask

  // registers only change while the allocator has nothing in flight
  task automatic configure(logic [31:0] base, logic [31:0] count, bit poke_unused);
    settle_requests();
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_BLOCK_COUNT, count);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed alloc/free traffic with some noise mixed in
  task automatic run_traffic(int n);
    int          k;
    int          lim;
    int          pick;
    int          blocks;
    int          firsts[$];
    logic [31:0] size;
    logic [31:0] addr;
    for (k = 0; k < n; k++) begin
      lim  = usable_blocks();
      pick = $urandom_range(99);
      firsts.delete();
      for (int i = 0; i < lim; i++)
        if ((shadow_table[i] & FLAG_FIRST) != '0) firsts.push_back(i);
      if (pick < 45) begin
        // sizes that fit, with random byte remainder inside the last block
        blocks = $urandom_range(1, (lim / 4 > 1) ? lim / 4 : 1);
        size   = (blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
        send_request(CMD_ALLOC, size, $urandom);
      end else if (pick < 80 && firsts.size() != 0) begin
        // release a live run, possibly through an unaligned address
        addr = shadow_base + firsts[$urandom_range(0, firsts.size() - 1)] * BLOCK_BYTES
               + $urandom_range(0, BLOCK_BYTES - 1);
        send_request(CMD_FREE, $urandom, addr);
      end else if (pick < 85) begin
        send_request(CMD_ALLOC, '0, $urandom);
      end else if (pick < 90) begin
        // full-width sizes, mostly far too big
        send_request(CMD_ALLOC, $urandom, $urandom);
      end else if (pick < 95 || lim == 0) begin
        send_request(CMD_FREE, $urandom, $urandom);
      end else begin
        // any block in range: free, first or middle of a chain
        addr = shadow_base + $urandom_range(0, lim - 1) * BLOCK_BYTES
               + $urandom_range(0, BLOCK_BYTES - 1);
        send_request(CMD_FREE, $urandom, addr);
      end
    end
  endtask

  // reset register values: zero size, rounding, no space, unaligned and
  // out-of-range frees, full-table run, free from the middle of a chain
  task automatic test_directed_requests();
    send_request(CMD_ALLOC, 32'h0,         32'h0);
    send_request(CMD_ALLOC, 32'h1,         32'h0);
    send_request(CMD_ALLOC, 32'h1000,      32'h0);
    send_request(CMD_ALLOC, 32'h1001,      32'h0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_FREE,  32'h0,         32'h1000);
    send_request(CMD_FREE,  32'h0,         32'h2800);
    send_request(CMD_FREE,  32'h0,         32'h3000);
    send_request(CMD_FREE,  32'h0,         32'h40_0000);
    send_request(CMD_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_FREE,  32'h0,         32'h0);
    send_request(CMD_ALLOC, 32'h40_0000,   32'h0);
    send_request(CMD_FREE,  32'h0,         32'h1000);
    send_request(CMD_ALLOC, 32'h2000,      32'h0);
    send_request(CMD_FREE,  32'h0,         32'h0);
  endtask

  // count zero, count above the table, single block, address wrap
  task automatic test_register_extremes();
    configure(32'h8000_0000, 32'd0, 1'b0);
    send_request(CMD_ALLOC, 32'h1,        32'h0);
    send_request(CMD_FREE,  32'h0,        32'h8000_0000);
    configure(32'h8000_0000, 32'd2047, 1'b0);
    send_request(CMD_ALLOC, 32'h40_0000,  32'h0);
    send_request(CMD_FREE,  32'h0,        32'h7FFF_FFFF);
    send_request(CMD_FREE,  32'h0,        32'h8000_0000);
    configure(32'hFFFF_E000, 32'd4, 1'b0);
    send_request(CMD_ALLOC, 32'h1000,     32'h0);
    send_request(CMD_ALLOC, 32'h2000,     32'h0);
    send_request(CMD_ALLOC, 32'h1000,     32'h0);
    send_request(CMD_FREE,  32'h0,        32'h1000);
    send_request(CMD_ALLOC, 32'h1,        32'h0);
    configure(32'hFFFF_FFFF, 32'd1, 1'b1);
    send_request(CMD_ALLOC, 32'h2000,     32'h0);
    send_request(CMD_ALLOC, 32'h1,        32'h0);
    send_request(CMD_FREE,  32'h0,        32'hFFFF_FFFF);
  endtask

  // random traffic over a spread of heap bases and block counts
  task automatic test_random_traffic();
    configure(32'h0001_0000, 32'd16, 1'b0);
    run_traffic(40);
    configure($urandom & 32'hFFFF_F000, $urandom_range(2, 64), 1'b0);
    run_traffic(40);
    // high base, later blocks wrap past zero
    configure(32'hFFF0_0000, 32'd1024, 1'b0);
    run_traffic(40);
    configure($urandom & 32'hFFFF_F000, 32'd2047, 1'b0);
    run_traffic(30);
    // unaligned base and a count above the table
    configure($urandom, $urandom_range(1025, 2047), 1'b1);
    run_traffic(30);
    configure($urandom & 32'hFFFF_F000, 32'd1, 1'b0);
    run_traffic(20);
    configure($urandom, $urandom_range(1, 32), 1'b0);
    run_traffic(22);
  endtask

  // a stretch with no idle cycles on either side
  task automatic test_back_to_back();
    configure($urandom & 32'hFFFF_F000, 32'd8, 1'b0);
    steady_flow = 1'b1;
    run_traffic(40);
    settle_requests();
    steady_flow = 1'b0;
  endtask

  // result side stalls at random unless running steady
  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 28);
  end

  // compare each result beat with the oldest owed answer
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_answers.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing owed: %h", out_tdata));
      end else begin
        want = owed_answers.pop_front();
        if (out_tdata[31:0] !== want.result_address)
          report_mismatch($sformatf("result_address got %h want %h",
                                    out_tdata[31:0], want.result_address));
        if (out_tdata[33:32] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_tdata[33:32], want.status));
      end
    end
  end

  initial begin
    foreach (shadow_table[i]) shadow_table[i] = '0;
    shadow_base  = '0;
    shadow_count = BCNT_W'(NUM_BLOCKS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_requests();
    test_register_extremes();
    test_random_traffic();
    test_back_to_back();
    settle_requests();
    // any stray beat would show up within one worst-case request time
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[block_table_heap_allocator] OK");
    end else begin
      $display("[block_table_heap_allocator] ERROR");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("[block_table_heap_allocator] ERROR");
    $finish;
  end

endmodule

/* block_table_heap_allocator.f */
sv/bta_pkg.sv
sv/bta_table_ram.sv
sv/bta_engine.sv
sv/block_table_heap_allocator.sv
dv/block_table_heap_allocator_test.sv
